// ===== design/rpn_pkg.sv =====
package rpn_pkg;

  localparam int STACK_DEPTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [3:0] ACT_PUSH = 4'd0;
  localparam logic [3:0] ACT_PEEK = 4'd1;
  localparam logic [3:0] ACT_ADD  = 4'd2;
  localparam logic [3:0] ACT_SUB  = 4'd3;
  localparam logic [3:0] ACT_MUL  = 4'd4;
  localparam logic [3:0] ACT_DIV  = 4'd5;
  localparam logic [3:0] ACT_SUM  = 4'd6;
  localparam logic [3:0] ACT_AVG  = 4'd7;
  localparam logic [3:0] ACT_SWAP = 4'd8;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_ONE   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_DIV0  = 3'd4;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] push_value;
  } rpn_in_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic               top_valid;
    logic [2:0]         status;
    logic [4:0]         depth;
  } rpn_out_t;

  // divider request/response between the sequencer and the divider
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [31:0] den;
  } rpn_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quot;
  } rpn_div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/rpn_stack_calculator.sv =====
// Channel  | Ports                           | Transfer
// ---------+---------------------------------+-------------------------------
// input    | start, busy, in_item            | start high while busy low
// result   | out_valid, out_item             | out_valid high for one cycle
//
// Every action ends with a top read (S_TOPRD, S_TOP); add, sub, mul, div and
// swap first read the two top entries, and div waits on the divider unless the
// divisor is zero. Sum walks the memory one entry per cycle; average adds a
// division on top. The single RAM read port and bit-serial divider set the pace.
// Reset (synchronous, rst_n low) empties the stack; memory is not cleared.
// The receiver cannot stall; each result shows for one cycle only.
module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rpn_in_t  in_item,
  output logic     out_valid,
  output rpn_out_t out_item
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDP   = 4'd1;
  localparam logic [3:0] S_RDQ   = 4'd2;
  localparam logic [3:0] S_OP    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIVW  = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_SUMF  = 4'd7;
  localparam logic [3:0] S_SWAP2 = 4'd8;
  localparam logic [3:0] S_TOPRD = 4'd9;
  localparam logic [3:0] S_TOP   = 4'd10;

  logic [3:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [3:0]         act_r, act_nxt;
  logic [2:0]         st_r, st_nxt;
  logic signed [31:0] p_r, p_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [65:0] acc_r, acc_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  rpn_out_t           out_r, out_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;
  rpn_div_req_t       dreq;
  rpn_div_rsp_t       drsp;
  logic signed [63:0] shr;

  rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  rpn_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // floor shift of the product
  assign shr = prod_r >>> FRACTION_BITS;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    st_nxt        = st_r;
    p_nxt         = p_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    dreq.start    = 1'b0;
    dreq.num      = '0;
    dreq.den      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = in_item.action;
          st_nxt  = ST_OK;
          case (in_item.action)
            ACT_PUSH: begin
              if (cnt_r >= CW'(STACK_DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = cnt_r[AW-1:0];
                wdata   = in_item.push_value;
                cnt_nxt = cnt_r + CW'(1);
              end
              state_nxt = S_TOPRD;
            end
            ACT_PEEK: begin
              if (cnt_r == '0) st_nxt = ST_EMPTY;
              state_nxt = S_TOPRD;
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_SWAP: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_TOPRD;
              end else if (cnt_r == CW'(1)) begin
                st_nxt    = ST_ONE;
                state_nxt = S_TOPRD;
              end else begin
                raddr     = AW'(cnt_r - CW'(1));
                state_nxt = S_RDP;
              end
            end
            ACT_SUM, ACT_AVG: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_TOPRD;
              end else begin
                raddr     = '0;
                idx_nxt   = CW'(1);
                acc_nxt   = '0;
                state_nxt = S_SUM;
              end
            end
            default: state_nxt = S_TOPRD;
          endcase
        end
      end
      S_RDP: begin
        p_nxt     = rdata;
        raddr     = AW'(cnt_r - CW'(2));
        state_nxt = S_RDQ;
      end
      S_RDQ: begin
        // hold the address so the second entry stays on the read port
        raddr     = AW'(cnt_r - CW'(2));
        state_nxt = S_OP;
      end
      S_OP: begin
        case (act_r)
          ACT_SWAP: begin
            we        = 1'b1;
            waddr     = AW'(cnt_r - CW'(1));
            wdata     = rdata;
            state_nxt = S_SWAP2;
          end
          ACT_ADD: begin
            we        = 1'b1;
            waddr     = AW'(cnt_r - CW'(2));
            wdata     = sat32(66'(signed'(rdata)) + 66'(p_r));
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_TOPRD;
          end
          ACT_SUB: begin
            we        = 1'b1;
            waddr     = AW'(cnt_r - CW'(2));
            wdata     = sat32(66'(signed'(rdata)) - 66'(p_r));
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_TOPRD;
          end
          ACT_MUL: begin
            prod_nxt  = signed'(rdata) * p_r;
            state_nxt = S_MUL;
          end
          default: begin
            if (p_r == '0) begin
              st_nxt    = ST_DIV0;
              we        = 1'b1;
              waddr     = AW'(cnt_r - CW'(2));
              wdata     = rdata[31] ? 32'h80000000 : 32'h7fffffff;
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = S_TOPRD;
            end else begin
              dreq.start = 1'b1;
              dreq.num   = 64'(signed'(rdata)) <<< FRACTION_BITS;
              dreq.den   = p_r;
              state_nxt  = S_DIVW;
            end
          end
        endcase
      end
      S_MUL: begin
        we        = 1'b1;
        waddr     = AW'(cnt_r - CW'(2));
        wdata     = sat32(66'(shr));
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_TOPRD;
      end
      S_SWAP2: begin
        we        = 1'b1;
        waddr     = AW'(cnt_r - CW'(2));
        wdata     = p_r;
        state_nxt = S_TOPRD;
      end
      S_SUM: begin
        // accumulate the entry read last cycle, issue the next read
        acc_nxt = acc_r + 66'(signed'(rdata));
        raddr   = AW'(idx_r);
        if (idx_r == cnt_r) begin
          state_nxt = S_SUMF;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SUMF: begin
        if (act_r == ACT_SUM) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = sat32(acc_r);
          cnt_nxt   = CW'(1);
          state_nxt = S_TOPRD;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = acc_r[63:0];
          dreq.den   = 32'(cnt_r);
          state_nxt  = S_DIVW;
        end
      end
      S_DIVW: begin
        if (drsp.done) begin
          we        = 1'b1;
          waddr     = (act_r == ACT_AVG) ? '0 : AW'(cnt_r - CW'(2));
          wdata     = sat32(66'(drsp.quot));
          cnt_nxt   = (act_r == ACT_AVG) ? CW'(1) : cnt_r - CW'(1);
          state_nxt = S_TOPRD;
        end
      end
      S_TOPRD: begin
        raddr     = AW'(cnt_r - CW'(1));
        state_nxt = S_TOP;
      end
      S_TOP: begin
        out_valid_nxt     = 1'b1;
        out_nxt.top_value = (cnt_r == '0) ? '0 : rdata;
        out_nxt.top_valid = (cnt_r != '0);
        out_nxt.status    = st_r;
        out_nxt.depth     = 5'(cnt_r);
        state_nxt         = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r  <= act_nxt;
    st_r   <= st_nxt;
    p_r    <= p_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    idx_r  <= idx_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== design/rpn_ram.sv =====
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rpn_div.sv =====
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module rpn_div import rpn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  rpn_div_req_t req,
  output rpn_div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[62:0], quo_r[63]};
    trial    = {1'b0, shifted} - {33'd0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      rem_nxt  = '0;
      quo_nxt  = req.num[63] ? 64'(-req.num) : req.num;
      den_nxt  = req.den[31] ? 32'(-req.den) : req.den;
      neg_nxt  = req.num[63] ^ req.den[31];
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? 64'(-quo_r) : quo_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rpn_pkg::*;

  localparam int DEPTH = 16;
  localparam int FRAC  = 16;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  rpn_in_t  in_item;
  logic     out_valid;
  rpn_out_t out_item;

  rpn_stack_calculator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // predictor state
  logic signed [31:0] model_stack [DEPTH];
  int                 model_count;
  rpn_out_t           pending_results [$];

  int  mismatches;
  int  results_seen;
  int  items_sent;
  int  op_hits [16];
  bit  calm;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic rpn_out_t predict_step(input rpn_in_t it);
    rpn_out_t           r;
    logic signed [31:0] p, q, res;
    logic signed [65:0] acc, prod;
    logic [2:0]         st;
    st = ST_OK;
    case (it.action)
      ACT_PUSH: begin
        if (model_count >= DEPTH) st = ST_FULL;
        else begin
          model_stack[model_count] = it.push_value;
          model_count++;
        end
      end
      ACT_PEEK: if (model_count == 0) st = ST_EMPTY;
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_SWAP: begin
        if (model_count == 0) st = ST_EMPTY;
        else if (model_count == 1) st = ST_ONE;
        else begin
          p = model_stack[model_count-1];
          q = model_stack[model_count-2];
          if (it.action == ACT_SWAP) begin
            model_stack[model_count-1] = q;
            model_stack[model_count-2] = p;
          end else begin
            case (it.action)
              ACT_ADD: res = clamp32(66'(q) + 66'(p));
              ACT_SUB: res = clamp32(66'(q) - 66'(p));
              ACT_MUL: begin
                prod = 66'(q) * 66'(p);
                res = clamp32(prod >>> FRAC);   // floor
              end
              default: begin
                if (p == 0) begin
                  st = ST_DIV0;
                  res = (q >= 0) ? 32'sh7fffffff : 32'sh80000000;
                end else begin
                  acc = 66'(q) <<< FRAC;
                  res = clamp32(acc / 66'(p));
                end
              end
            endcase
            model_count--;
            model_stack[model_count-1] = res;
          end
        end
      end
      ACT_SUM, ACT_AVG: begin
        if (model_count == 0) st = ST_EMPTY;
        else begin
          acc = '0;
          for (int i = 0; i < model_count; i++) acc += 66'(model_stack[i]);
          if (it.action == ACT_AVG) acc = acc / 66'(model_count);
          model_stack[0] = clamp32(acc);
          model_count = 1;
        end
      end
      default: ;
    endcase
    r.top_value = model_count > 0 ? model_stack[model_count-1] : 32'sd0;
    r.top_valid = model_count > 0;
    r.status    = st;
    r.depth     = 5'(model_count);
    return r;
  endfunction

  // send one item; inputs move on the falling edge
  task automatic send_item(input logic [3:0] act, input logic signed [31:0] val);
    rpn_in_t it;
    if (!calm) begin
      while ($urandom_range(99) < 15) @(negedge clk);
    end
    it.action = act;
    it.push_value = val;
    start <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(predict_step(it));
    op_hits[act]++;
    items_sent++;
    @(negedge clk);
    start <= 1'b0;
    in_item <= '0;
    // the block stays busy here, so this wait does not delay the next transfer
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    rpn_out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item.top_value !== want.top_value || out_item.top_valid !== want.top_valid ||
            out_item.status !== want.status || out_item.depth !== want.depth) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", want, out_item);
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(int'($urandom_range(20)) - 10) <<< FRAC;
      3: return 32'(int'($urandom_range(200000)) - 100000);
      4: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_ops();
    for (int a = 1; a <= 8; a++) send_item(4'(a), 0);
    send_item(4'd9, 0);
    send_item(4'd15, 32'sh7fffffff);
  endtask

  task automatic test_one_entry();
    send_item(ACT_PUSH, 32'sh80000000);
    for (int a = 2; a <= 5; a++) send_item(4'(a), 0);
    send_item(ACT_SWAP, 0);
    send_item(ACT_PEEK, 0);
  endtask

  task automatic test_saturation();
    send_item(ACT_PUSH, 32'sh7fffffff); send_item(ACT_PUSH, 32'sh7fffffff);
    send_item(ACT_ADD, 0);
    send_item(ACT_PUSH, 32'sh80000000); send_item(ACT_MUL, 0);
    send_item(ACT_PUSH, 32'sd0); send_item(ACT_DIV, 0);
    send_item(ACT_PUSH, 32'sh80000000); send_item(ACT_PUSH, 32'sd0);
    send_item(ACT_DIV, 0);
    send_item(ACT_PUSH, 32'sh80000000); send_item(ACT_PUSH, -32'sd1);
    send_item(ACT_DIV, 0);
    send_item(ACT_SWAP, 0); send_item(ACT_SUB, 0);
  endtask

  task automatic test_full_stack();
    while (model_count < DEPTH) send_item(ACT_PUSH, 32'sh7fffffff);
    send_item(ACT_PUSH, -32'sd5);
    send_item(ACT_AVG, 0);
    while (model_count < DEPTH) send_item(ACT_PUSH, 32'sh80000000);
    send_item(ACT_SUM, 0);
  endtask

  // mostly well-formed expressions, with some noise on top
  task automatic test_random(input int n_items);
    int k;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 3) calm = 1'b1;
      if (i == n_items / 2) calm = 1'b0;
      k = $urandom_range(99);
      if (k < 40 && model_count < DEPTH) send_item(ACT_PUSH, rand_value());
      else if (k < 85) send_item(4'($urandom_range(2, 8)), $urandom);
      else if (k < 92) send_item(ACT_PEEK, $urandom);
      else if (k < 96) send_item(4'($urandom_range(9, 15)), $urandom);
      else send_item(4'($urandom_range(8)), rand_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    model_count = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    calm = 1'b0;
    foreach (op_hits[i]) op_hits[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_ops();
    test_one_entry();
    test_saturation();
    test_full_stack();
    test_random(1900);

    wait_drained();
    repeat (200) @(negedge clk);
    $display("Sent %0d items, checked %0d results; pushes %0d, divides %0d, averages %0d",
             items_sent, results_seen, op_hits[ACT_PUSH], op_hits[ACT_DIV], op_hits[ACT_AVG]);
    $display("Empty, one-entry, full-stack, saturation and divide-by-zero cases exercised");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out waiting for the calculator");
    $display("Regression FAIL");
    $finish;
  end

endmodule
